// ===== rtl/c8dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// c8dfr_pkg
// Types, constants and the CRC-8 step shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package c8dfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int ERRCNT_W = 16;
  localparam int KIND_W   = 3;
  localparam int CFG_AW   = 2;

  // payload store depth, also the hard cap on the accepted length
  localparam int PAY_DEPTH = 16;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_START_BYTE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_END_BYTE     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LENGTH_LIMIT = 2'd2;

  localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'd170;
  localparam logic [BYTE_W-1:0] END_BYTE_RST     = 8'd85;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR     = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_LEN_ERR = 3'd2,
    KIND_CRC_ERR = 3'd3,
    KIND_END_ERR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_CMD     = 3'd1,
    ST_LEN     = 3'd2,
    ST_PAY     = 3'd3,
    ST_CRC     = 3'd4,
    ST_END     = 3'd5,
    ST_EMIT_RD = 3'd6,
    ST_EMIT_LD = 3'd7
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic  frame_start;
    logic  take_cmd;
    logic  take_len;
    logic  take_pay;
    logic  err_inc;
    logic  emit_clr;
    logic  emit_adv;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic len_bad;
    logic rx_len_zero;
    logic frame_len_zero;
    logic pay_done;
    logic crc_ok;
    logic end_ok;
    logic emit_last;
  } dp_status_t;

  // one byte through the CRC-8 shift register, MSB first
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/c8dfr_ifs.sv =====
// ----------------------------------------------------------------------------
// c8dfr_ifs
// Valid/ready channels for received bytes and parsed results.
// ----------------------------------------------------------------------------
interface c8dfr_in_if import c8dfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface c8dfr_out_if import c8dfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   command;
  logic [LEN_W-1:0]    length;
  logic [BYTE_W-1:0]   data;
  logic                last;
  logic [ERRCNT_W-1:0] error_count;

  modport source (output valid, output kind, output command, output length,
                  output data, output last, output error_count, input ready);
  modport sink   (input valid, input kind, input command, input length,
                  input data, input last, input error_count, output ready);
endinterface

// ===== rtl/crc8_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// crc8_packet_deframer_unit
// Parses start/command/length/payload/CRC-8/end frames from a byte stream.
// ----------------------------------------------------------------------------
// Results: an error or header result is in the output register in the cycle
//   after the byte that ends the frame is taken.
// Throughput: one byte per cycle while parsing; payload readout passes through
//   a read state and a load state per byte (registered read of the payload
//   memory); no byte is taken while a result waits in the output register.
// Reset: synchronous, active low; config returns to its defaults, the payload
//   memory is not cleared.
module crc8_packet_deframer_unit import c8dfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  c8dfr_in_if.sink            in_if,
  c8dfr_out_if.source         out_if,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [BYTE_W-1:0]   cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  kind_t      kind;

  c8dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  c8dfr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .rx_byte         (in_if.rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_kind        (kind),
    .out_command     (out_if.command),
    .out_length      (out_if.length),
    .out_data        (out_if.data),
    .out_last        (out_if.last),
    .out_error_count (out_if.error_count)
  );

  assign out_if.kind = kind;

  err_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (kind == KIND_LEN_ERR || kind == KIND_CRC_ERR ||
                     kind == KIND_END_ERR) |-> out_if.last)
    else $error("error result not marked last");

  data_zero_off_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && kind != KIND_DATA |-> out_if.data == '0)
    else $error("nonzero data on a non-payload result");

endmodule

// ===== rtl/c8dfr_datapath.sv =====
// ----------------------------------------------------------------------------
// c8dfr_datapath
// Config registers, running CRC, frame fields, payload memory, error counter
// and the result register.
// ----------------------------------------------------------------------------
module c8dfr_datapath import c8dfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [BYTE_W-1:0]   cfg_wdata,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  output kind_t               out_kind,
  output logic [BYTE_W-1:0]   out_command,
  output logic [LEN_W-1:0]    out_length,
  output logic [BYTE_W-1:0]   out_data,
  output logic                out_last,
  output logic [ERRCNT_W-1:0] out_error_count
);

  logic [BYTE_W-1:0]   start_byte_r;
  logic [BYTE_W-1:0]   end_byte_r;
  logic [LEN_W-1:0]    length_limit_r;

  logic [BYTE_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]   fcmd_r;
  logic [LEN_W-1:0]    flen_r, flen_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic [ERRCNT_W-1:0] err_r, err_nxt;
  logic [BYTE_W-1:0]   rd_data_r;
  logic [BYTE_W-1:0]   mem [PAY_DEPTH];

  logic [BYTE_W-1:0]   lim_eff;

  kind_t               kind_r;
  logic [BYTE_W-1:0]   ocmd_r;
  logic [LEN_W-1:0]    olen_r;
  logic [BYTE_W-1:0]   odata_r;
  logic                olast_r;
  logic [ERRCNT_W-1:0] oerr_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= START_BYTE_RST;
      end_byte_r     <= END_BYTE_RST;
      length_limit_r <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_BYTE:   start_byte_r   <= cfg_wdata;
        REG_END_BYTE:     end_byte_r     <= cfg_wdata;
        REG_LENGTH_LIMIT: length_limit_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(length_limit_r) > PAY_DEPTH) begin
      lim_eff = BYTE_W'(PAY_DEPTH);
    end else begin
      lim_eff = BYTE_W'(length_limit_r);
    end
  end

  always_comb begin
    status.is_start       = (rx_byte == start_byte_r);
    status.len_bad        = (rx_byte > lim_eff);
    status.rx_len_zero    = (rx_byte == '0);
    status.frame_len_zero = (flen_r == '0);
    status.pay_done       = ({1'b0, idx_r} + (LEN_W+1)'(1)) >= {1'b0, flen_r};
    status.crc_ok         = (crc_r == rx_byte);
    status.end_ok         = (rx_byte == end_byte_r);
    status.emit_last      = ({1'b0, emit_idx_r} + (LEN_W+1)'(1)) == {1'b0, flen_r};
  end

  always_comb begin
    crc_nxt      = crc_r;
    flen_nxt     = flen_r;
    idx_nxt      = idx_r;
    emit_idx_nxt = emit_idx_r;
    err_nxt      = err_r;
    if (cmd.frame_start) begin
      crc_nxt = '0;
      idx_nxt = '0;
    end
    if (cmd.take_cmd) begin
      crc_nxt = crc8_update('0, rx_byte);
    end
    if (cmd.take_len) begin
      idx_nxt = '0;
      if (status.len_bad) begin
        flen_nxt = '0;
      end else begin
        flen_nxt = rx_byte[LEN_W-1:0];
        crc_nxt  = crc8_update(crc_r, rx_byte);
      end
    end
    if (cmd.take_pay) begin
      idx_nxt = idx_r + LEN_W'(1);
      crc_nxt = crc8_update(crc_r, rx_byte);
    end
    if (cmd.err_inc) begin
      err_nxt = err_r + ERRCNT_W'(1);
    end
    if (cmd.emit_clr) begin
      emit_idx_nxt = '0;
    end else if (cmd.emit_adv) begin
      emit_idx_nxt = emit_idx_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= '0;
      fcmd_r     <= '0;
      flen_r     <= '0;
      idx_r      <= '0;
      emit_idx_r <= '0;
      err_r      <= '0;
    end else begin
      crc_r      <= crc_nxt;
      flen_r     <= flen_nxt;
      idx_r      <= idx_nxt;
      emit_idx_r <= emit_idx_nxt;
      err_r      <= err_nxt;
      if (cmd.take_cmd) begin
        fcmd_r <= rx_byte;
      end
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_pay && (32'(idx_r) < PAY_DEPTH)) begin
      mem[PAY_AW'(idx_r)] <= rx_byte;
    end
    rd_data_r <= mem[PAY_AW'(emit_idx_r)];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_HDR;
    end else if (cmd.out_load) begin
      kind_r <= cmd.out_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocmd_r  <= fcmd_r;
      olen_r  <= flen_nxt;
      odata_r <= (cmd.out_kind == KIND_DATA) ? rd_data_r : '0;
      olast_r <= cmd.out_last;
      oerr_r  <= err_nxt;
    end
  end

  assign out_kind        = kind_r;
  assign out_command     = ocmd_r;
  assign out_length      = olen_r;
  assign out_data        = odata_r;
  assign out_last        = olast_r;
  assign out_error_count = oerr_r;

  err_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err_inc |=> err_r == $past(err_r) + ERRCNT_W'(1))
    else $error("error counter did not advance by one");

endmodule

// ===== rtl/c8dfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// c8dfr_ctrl
// Frame parser state machine and result-register valid flag.
// ----------------------------------------------------------------------------
module c8dfr_ctrl import c8dfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   parse_st;
  logic   acc;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    parse_st = 1'b0;
    unique case (state_r)
      ST_WAIT, ST_CMD, ST_LEN, ST_PAY, ST_CRC, ST_END: parse_st = 1'b1;
      default: parse_st = 1'b0;
    endcase
  end

  // hold input while a result waits
  assign in_ready  = parse_st && !out_valid_r;
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_WAIT: begin
        if (acc && status.is_start) begin
          cmd.frame_start = 1'b1;
          state_nxt       = ST_CMD;
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd.take_cmd = 1'b1;
          state_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (acc) begin
          cmd.take_len = 1'b1;
          if (status.len_bad) begin
            cmd.err_inc  = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_LEN_ERR;
            cmd.out_last = 1'b1;
            state_nxt    = ST_WAIT;
          end else if (status.rx_len_zero) begin
            state_nxt = ST_CRC;
          end else begin
            state_nxt = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        if (acc) begin
          cmd.take_pay = 1'b1;
          if (status.pay_done) begin
            state_nxt = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (acc) begin
          if (!status.crc_ok) begin
            cmd.err_inc  = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_CRC_ERR;
            cmd.out_last = 1'b1;
            state_nxt    = ST_WAIT;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (acc) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_WAIT;
          if (!status.end_ok) begin
            cmd.err_inc  = 1'b1;
            cmd.out_kind = KIND_END_ERR;
          end else begin
            cmd.out_kind = KIND_HDR;
            cmd.out_last = status.frame_len_zero;
            cmd.emit_clr = 1'b1;
            if (!status.frame_len_zero) begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end
      ST_EMIT_RD: begin
        // memory read data lands next cycle
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DATA;
          cmd.out_last = status.emit_last;
          if (status.emit_last) begin
            state_nxt = ST_WAIT;
          end else begin
            cmd.emit_adv = 1'b1;
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before it was taken");

  emit_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_RD |=> state_r == ST_EMIT_LD)
    else $error("payload readout skipped its load step");

endmodule

// ===== tb/crc8_packet_deframer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_deframer_unit_test
// Drives byte streams of good, corrupted and truncated frames into the
// deframer under several start/end/limit settings. It predicts the header,
// payload and error results cycle-independently and checks every result
// transaction in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module crc8_packet_deframer_unit_test;
  import c8dfr_pkg::*;

  localparam int          IDLE_LIMIT     = 2000;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          SETTLE_CYCLES  = 4;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  typedef enum {FR_GOOD, FR_BAD_LEN, FR_BAD_CRC, FR_BAD_END} frame_flavor_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   command;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [ERRCNT_W-1:0] error_count;
  } frame_result_t;

  // Parser shadow: follows every accepted byte and queues the results it owes.
  class frame_checker;
    logic [BYTE_W-1:0]   start_val;
    logic [BYTE_W-1:0]   end_val;
    logic [LEN_W-1:0]    limit_val;
    state_t              parse_st;
    logic [BYTE_W-1:0]   crc_acc;
    logic [BYTE_W-1:0]   cmd_r;
    logic [LEN_W-1:0]    len_r;
    logic [5:0]          idx_r;
    logic [BYTE_W-1:0]   pay_mem [PAY_DEPTH];
    logic [ERRCNT_W-1:0] err_cnt;
    frame_result_t       owed_results[$];
    int unsigned         failures;

    function new();
      start_val = START_BYTE_RST;
      end_val   = END_BYTE_RST;
      limit_val = LENGTH_LIMIT_RST;
      parse_st  = ST_WAIT;
      crc_acc   = '0;
      cmd_r     = '0;
      len_r     = '0;
      idx_r     = '0;
      err_cnt   = '0;
      failures  = 0;
    endfunction

    function logic [BYTE_W-1:0] crc8_shift(logic [BYTE_W-1:0] crc, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      logic              msb;
      c = crc ^ b;
      repeat (BYTE_W) begin
        msb = c[BYTE_W-1];
        c = {c[BYTE_W-2:0], 1'b0} ^ (msb ? CRC_POLY : '0);
      end
      return c;
    endfunction

    function int unsigned eff_limit();
      return (limit_val > PAY_DEPTH) ? PAY_DEPTH : limit_val;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_START_BYTE:   start_val = val;
        REG_END_BYTE:     end_val   = val;
        REG_LENGTH_LIMIT: limit_val = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_result(kind_t k, logic [BYTE_W-1:0] d, logic l);
      frame_result_t r;
      r.kind        = k;
      r.command     = cmd_r;
      r.length      = len_r;
      r.data        = d;
      r.last        = l;
      r.error_count = err_cnt;
      owed_results.push_back(r);
    endfunction

    function void flag_error(kind_t k);
      err_cnt++;
      push_result(k, '0, 1'b1);
      parse_st = ST_WAIT;
      idx_r    = '0;
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] b);
      case (parse_st)
        ST_CMD: begin
          cmd_r    = b;
          crc_acc  = crc8_shift('0, b);
          parse_st = ST_LEN;
        end
        ST_LEN: begin
          if (b > eff_limit()) begin
            len_r = '0;
            flag_error(KIND_LEN_ERR);
          end else begin
            len_r    = b[LEN_W-1:0];
            crc_acc  = crc8_shift(crc_acc, b);
            idx_r    = '0;
            parse_st = (b == 0) ? ST_CRC : ST_PAY;
          end
        end
        ST_PAY: begin
          if (idx_r < PAY_DEPTH) begin
            pay_mem[idx_r[PAY_AW-1:0]] = b;
          end
          idx_r   = idx_r + 1'b1;
          crc_acc = crc8_shift(crc_acc, b);
          if (idx_r >= len_r) begin
            parse_st = ST_CRC;
          end
        end
        ST_CRC: begin
          if (crc_acc != b) begin
            flag_error(KIND_CRC_ERR);
          end else begin
            parse_st = ST_END;
          end
        end
        ST_END: begin
          if (b != end_val) begin
            flag_error(KIND_END_ERR);
          end else begin
            parse_st = ST_WAIT;
            idx_r    = '0;
            push_result(KIND_HDR, '0, len_r == 0);
            for (int k = 0; k < len_r; k++) begin
              push_result(KIND_DATA, pay_mem[k], k + 1 == len_r);
            end
          end
        end
        default: begin
          // unused codes fall back to hunting
          parse_st = ST_WAIT;
          if (b == start_val) begin
            parse_st = ST_CMD;
            crc_acc  = '0;
            idx_r    = '0;
          end
        end
      endcase
    endfunction

    function void compare_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      end
    endfunction

    function void match_result(frame_result_t got);
      frame_result_t want;
      if (owed_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual kind %0d cmd %0h data %0h",
                 $time, got.kind, got.command, got.data);
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("command", want.command, got.command);
      compare_field("length", want.length, got.length);
      compare_field("data", want.data, got.data);
      compare_field("last", want.last, got.last);
      compare_field("error_count", want.error_count, got.error_count);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [BYTE_W-1:0] cfg_wdata;

  c8dfr_in_if  in_ch ();
  c8dfr_out_if out_ch ();

  frame_checker sb = new();

  bit          calm;
  bit          hold_req;
  int unsigned frame_items;
  int unsigned stuck_cycles;

  crc8_packet_deframer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind        = kind_t'(out_ch.kind);
      got.command     = out_ch.command;
      got.length      = out_ch.length;
      got.data        = out_ch.data;
      got.last        = out_ch.last;
      got.error_count = out_ch.error_count;
      sb.match_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    sb.parse_byte(b);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len_byte,
                            input logic [BYTE_W-1:0] body[$], input frame_flavor_t flavor);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] wrong;
    send_byte(sb.start_val);
    send_byte(cmd);
    send_byte(len_byte);
    frame_items += 3;
    if (flavor == FR_BAD_LEN) begin
      return;
    end
    crc = sb.crc8_shift(sb.crc8_shift('0, cmd), len_byte);
    foreach (body[i]) begin
      send_byte(body[i]);
      crc = sb.crc8_shift(crc, body[i]);
    end
    // a bad check or end byte equal to the start byte must not reopen a frame
    if (flavor == FR_BAD_CRC) begin
      wrong = (crc != sb.start_val) ? sb.start_val : crc ^ 8'($urandom_range(1, 255));
      send_byte(wrong);
      frame_items += body.size() + 1;
      return;
    end
    send_byte(crc);
    if (flavor == FR_BAD_END) begin
      wrong = (sb.end_val != sb.start_val) ? sb.start_val
                                           : sb.end_val ^ 8'($urandom_range(1, 255));
      send_byte(wrong);
    end else begin
      send_byte(sb.end_val);
    end
    frame_items += body.size() + 2;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned       first;
    int unsigned       pick;
    int unsigned       eff;
    int unsigned       len;
    int unsigned       k;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] body[$];
    first = frame_items;
    while (frame_items - first < target) begin
      eff  = sb.eff_limit();
      pick = $urandom_range(0, 99);
      cmd  = 8'($urandom_range(0, 255));
      len  = ($urandom_range(0, 9) == 0) ? eff : $urandom_range(0, (eff < 5) ? eff : 5);
      body.delete();
      for (k = 0; k < len; k++) begin
        body.push_back(8'($urandom_range(0, 255)));
      end
      if (pick < 70) begin
        send_frame(cmd, 8'(len), body, FR_GOOD);
      end else if (pick < 78) begin
        send_frame(cmd, 8'($urandom_range(eff + 1, 255)), body, FR_BAD_LEN);
      end else if (pick < 86) begin
        send_frame(cmd, 8'(len), body, FR_BAD_CRC);
      end else if (pick < 93) begin
        send_frame(cmd, 8'(len), body, FR_BAD_END);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(0, 3) == 0) ? sb.start_val : 8'($urandom_range(0, 255)));
        end
      end
      // feed filler until the parser hunts again
      while (sb.parse_st != ST_WAIT) begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    logic [BYTE_W-1:0] body[$];
    calm          = 1'b0;
    hold_req      = 1'b0;
    frame_items   = 0;
    stuck_cycles  = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero-length frame, then a short frame with extreme command and payload
    send_frame(8'h00, 8'h00, body, FR_GOOD);
    body = '{8'h00, 8'hFF};
    send_frame(8'hFF, 8'h02, body, FR_GOOD);
    body.delete();
    send_frame(8'h5A, 8'hFF, body, FR_BAD_LEN);
    send_frame(8'h01, 8'(PAY_DEPTH + 1), body, FR_BAD_LEN);
    send_frame(8'h12, 8'h00, body, FR_BAD_CRC);
    send_frame(8'h34, 8'h00, body, FR_BAD_END);
    run_random(80);
    drain();

    // limit zero via upper bits set in the data word; unused index too
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hFF);
    write_reg(REG_LENGTH_LIMIT, 8'hE0);
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    run_random(50);
    drain();

    // limit above the store depth; hold results so the input stalls
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h00);
    write_reg(REG_LENGTH_LIMIT, 8'h1F);
    hold_req = 1'b1;
    run_random(80);
    drain();

    write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_END_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_LENGTH_LIMIT, {3'($urandom_range(0, 7)), 5'($urandom_range(1, 16))});
    calm = 1'b1;
    run_random(70);
    drain();
    repeat (10) @(posedge clk);

    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
